// ===== sv/pps_pkg.sv =====
// pps_pkg: shared types, constants and helpers for the particle pool stepper
// no dependencies
package pps_pkg;

    localparam int POOL_SIZE = 64;
    localparam int SLOT_W    = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int DAMP_Q16  = 3277;
    localparam int GRAV_Q16  = 13107;
    localparam int LIFE_W    = 18;
    localparam logic [LIFE_W-1:0] LIFE_START_RST = 18'd196608;

    typedef enum logic [1:0] {
        MODE_SPAWN = 2'd0,
        MODE_TICK  = 2'd1,
        MODE_DRAW  = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        KIND_SPAWNED   = 3'd0,
        KIND_DROPPED   = 3'd1,
        KIND_TICK_DONE = 3'd2,
        KIND_ENTRY     = 3'd3,
        KIND_NONE      = 3'd4
    } t_kind;

    typedef struct packed {
        t_mode              mode;
        logic signed [31:0] spawn_x;
        logic signed [31:0] spawn_y;
        logic signed [31:0] spawn_vx;
        logic signed [31:0] spawn_vy;
        logic [15:0]        spawn_size;
        logic [15:0]        tick_step;
    } t_in;

    typedef struct packed {
        t_kind              kind;
        logic               need_draw;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic [15:0]        out_size;
        logic               last;
    } t_out;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [18:0] life;
        logic [15:0]        size;
    } t_part;

    localparam int PART_W = $bits(t_part);

    typedef struct packed {
        logic              capture;
        logic              rd_en;
        logic              tick_rd;
        logic              spawn_wr;
        logic              out_load;
        t_kind             out_kind;
        logic              out_from_ram;
        logic              out_last;
        logic [SLOT_W-1:0] slot;
    } t_cmd;

    typedef struct packed {
        logic slot_alive;
        logic any_alive;
        logic more_above;
        logic out_free;
        logic tick_busy;
    } t_stat;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -34'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/pps_ram.sv =====
// pps_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module pps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/pps_dp.sv =====
// pps_dp: particle store, alive bits, tick update pipeline and output register
// depends on pps_pkg and pps_ram
module pps_dp
    import pps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_in               i_in_data,
    input  logic              i_cfg_wr,
    input  logic [LIFE_W-1:0] i_cfg_data,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out              o_out_data
);

    t_in                r_in;
    logic [LIFE_W-1:0]  r_life_start;
    logic signed [17:0] r_factor;
    logic [15:0]        r_grav;
    logic               r_any;
    logic [POOL_SIZE-1:0] r_alive;

    logic [28:0] damp_mul;
    logic [29:0] grav_mul;

    t_part rd_part;
    t_part wr_part;
    logic  wr_en;
    logic [SLOT_W-1:0] wr_addr;

    logic               r_s1_vld;
    logic [SLOT_W-1:0]  r_s1_slot;
    logic               r_s2_vld;
    logic [SLOT_W-1:0]  r_s2_slot;
    logic signed [48:0] r_px_prod;
    logic signed [48:0] r_py_prod;
    logic signed [49:0] r_vx_prod;
    logic signed [49:0] r_vy_prod;
    logic signed [31:0] r_s2_pos_x;
    logic signed [31:0] r_s2_pos_y;
    logic signed [18:0] r_s2_life;
    logic [15:0]        r_s2_size;

    logic signed [48:0] px_rnd;
    logic signed [48:0] py_rnd;
    logic signed [49:0] vx_rnd;
    logic signed [49:0] vy_rnd;
    logic signed [31:0] vy_damped;
    logic signed [31:0] new_vy;
    logic               keep;
    logic [POOL_SIZE:0] above;

    t_out r_out;
    logic r_out_valid;
    logic out_free;

    assign damp_mul = 29'(DAMP_Q16) * 29'(i_in_data.tick_step) + 29'd32768;
    assign grav_mul = 30'(GRAV_Q16) * 30'(i_in_data.tick_step) + 30'd32768;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_life_start <= LIFE_START_RST;
        end else if (i_cfg_wr) begin
            r_life_start <= i_cfg_data;
        end
        if (i_cmd.capture) begin
            r_in     <= i_in_data;
            r_factor <= 18'sd65536 - $signed({5'd0, damp_mul[28:16]});
            r_grav   <= {2'd0, grav_mul[29:16]};
        end
    end

    pps_ram #(
        .WIDTH(PART_W),
        .DEPTH(POOL_SIZE)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_part),
        .i_rd_en  (i_cmd.rd_en),
        .i_rd_addr(i_cmd.slot),
        .o_rd_data(rd_part)
    );

    // stage 1: products from the read slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_cmd.tick_rd && r_alive[i_cmd.slot];
            r_s2_vld <= r_s1_vld;
        end
        r_s1_slot  <= i_cmd.slot;
        r_s2_slot  <= r_s1_slot;
        r_px_prod  <= $signed({1'b0, r_in.tick_step}) * rd_part.vel_x;
        r_py_prod  <= $signed({1'b0, r_in.tick_step}) * rd_part.vel_y;
        r_vx_prod  <= r_factor * rd_part.vel_x;
        r_vy_prod  <= r_factor * rd_part.vel_y;
        r_s2_pos_x <= rd_part.pos_x;
        r_s2_pos_y <= rd_part.pos_y;
        r_s2_life  <= rd_part.life - $signed({3'd0, r_in.tick_step});
        r_s2_size  <= rd_part.size;
    end

    // stage 2: round, saturate and write back
    always_comb begin
        px_rnd    = r_px_prod + 49'sd32768;
        py_rnd    = r_py_prod + 49'sd32768;
        vx_rnd    = r_vx_prod + 50'sd32768;
        vy_rnd    = r_vy_prod + 50'sd32768;
        vy_damped = sat32(vy_rnd[49:16]);
        new_vy    = sat32({{2{vy_damped[31]}}, vy_damped} + $signed({18'd0, r_grav}));
        keep      = !r_s2_life[18] && (r_s2_life != 19'sd0);
        if (i_cmd.spawn_wr) begin
            wr_addr       = i_cmd.slot;
            wr_part.pos_x = r_in.spawn_x;
            wr_part.pos_y = r_in.spawn_y;
            wr_part.vel_x = r_in.spawn_vx;
            wr_part.vel_y = r_in.spawn_vy;
            wr_part.life  = $signed({1'b0, r_life_start});
            wr_part.size  = r_in.spawn_size;
        end else begin
            wr_addr       = r_s2_slot;
            wr_part.pos_x = sat32({{2{r_s2_pos_x[31]}}, r_s2_pos_x}
                                  + {px_rnd[48], px_rnd[48:16]});
            wr_part.pos_y = sat32({{2{r_s2_pos_y[31]}}, r_s2_pos_y}
                                  + {py_rnd[48], py_rnd[48:16]});
            wr_part.vel_x = sat32(vx_rnd[49:16]);
            wr_part.vel_y = new_vy;
            wr_part.life  = r_s2_life;
            wr_part.size  = r_s2_size;
        end
        wr_en = i_cmd.spawn_wr || r_s2_vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive <= '0;
            r_any   <= 1'b0;
        end else begin
            if (i_cmd.spawn_wr) begin
                r_alive[i_cmd.slot] <= 1'b1;
            end else if (r_s2_vld) begin
                r_alive[r_s2_slot] <= keep;
            end
            if (i_cmd.capture) begin
                r_any <= 1'b0;
            end else if (i_cmd.tick_rd && r_alive[i_cmd.slot]) begin
                r_any <= 1'b1;
            end
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out.kind      <= i_cmd.out_kind;
            r_out.need_draw <= (i_cmd.out_kind == KIND_TICK_DONE) && r_any;
            r_out.out_x     <= i_cmd.out_from_ram ? rd_part.pos_x : 32'sd0;
            r_out.out_y     <= i_cmd.out_from_ram ? rd_part.pos_y : 32'sd0;
            r_out.out_size  <= i_cmd.out_from_ram ? rd_part.size : 16'd0;
            r_out.last      <= i_cmd.out_last;
        end
    end

    assign above = {1'b0, r_alive} >> i_cmd.slot;

    assign o_stat.slot_alive = r_alive[i_cmd.slot];
    assign o_stat.any_alive  = |r_alive;
    assign o_stat.more_above = |above[POOL_SIZE:1];
    assign o_stat.out_free   = out_free;
    assign o_stat.tick_busy  = r_s1_vld || r_s2_vld;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

`ifndef ASSERT_OFF
    a_wr_port_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.spawn_wr && r_s2_vld))
        else $error("spawn write collides with tick writeback");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> out_free)
        else $error("output register overwritten");
    a_spawn_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.spawn_wr |-> !r_alive[i_cmd.slot])
        else $error("spawn into an active slot");
`endif

endmodule

// ===== sv/pps_ctrl.sv =====
// pps_ctrl: sequencer for spawn search, tick sweep and draw walk
// depends on pps_pkg
module pps_ctrl
    import pps_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_mode i_mode,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SPAWN,
        S_TICK,
        S_TDRAIN,
        S_DSTART,
        S_DRAW,
        S_DWAIT
    } t_state;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(POOL_SIZE - 1);

    t_state            r_state;
    t_state            n_state;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] n_slot;
    logic              at_end;

    assign at_end = (r_slot == LAST_SLOT);

    always_comb begin
        n_state            = r_state;
        n_slot             = r_slot;
        o_cmd              = '0;
        o_cmd.out_kind     = KIND_SPAWNED;
        o_cmd.slot         = r_slot;
        o_in_ready         = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                n_slot = '0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    case (i_mode)
                        MODE_SPAWN: n_state = S_SPAWN;
                        MODE_TICK:  n_state = S_TICK;
                        MODE_DRAW:  n_state = S_DSTART;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_SPAWN: begin
                if (!i_stat.slot_alive) begin
                    if (i_stat.out_free) begin
                        o_cmd.spawn_wr = 1'b1;
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_kind = KIND_SPAWNED;
                        o_cmd.out_last = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else if (at_end) begin
                    if (i_stat.out_free) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_kind = KIND_DROPPED;
                        o_cmd.out_last = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            S_TICK: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.tick_rd = 1'b1;
                n_slot        = r_slot + 1'b1;
                if (at_end) begin
                    n_state = S_TDRAIN;
                end
            end
            S_TDRAIN: begin
                if (!i_stat.tick_busy && i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = KIND_TICK_DONE;
                    o_cmd.out_last = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_DSTART: begin
                if (i_stat.any_alive) begin
                    n_state = S_DRAW;
                end else if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = KIND_NONE;
                    o_cmd.out_last = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_DRAW: begin
                if (i_stat.slot_alive) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_DWAIT;
                end else if (at_end) begin
                    n_state = S_IDLE;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            S_DWAIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load     = 1'b1;
                    o_cmd.out_kind     = KIND_ENTRY;
                    o_cmd.out_from_ram = 1'b1;
                    o_cmd.out_last     = !i_stat.more_above;
                    if (!i_stat.more_above) begin
                        n_state = S_IDLE;
                    end else begin
                        n_slot  = r_slot + 1'b1;
                        n_state = S_DRAW;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_slot  <= '0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
        end
    end

`ifndef ASSERT_OFF
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !i_stat.tick_busy)
        else $error("tick pipeline busy while idle");
    a_draw_read_alive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DWAIT) |-> i_stat.slot_alive)
        else $error("draw emits an inactive slot");
`endif

endmodule

// ===== sv/particle_pool_stepper_core.sv =====
// particle_pool_stepper_core: top level of the particle pool stepper
// depends on pps_pkg, pps_ctrl, pps_dp and pps_ram
//
// Input channel i_in_*: one transaction is a spawn, tick or draw command;
// mode 3 is taken and ignored. Output channel o_out_*: result transactions,
// last marks the final result of a command. Config channel i_cfg_*: writes
// life_start, always ready; write it only while the block is idle.
// One command is worked at a time; in_ready is high only when idle.
// Spawn: scans slots one per cycle for the lowest free one.
// Tick: sweeps all 64 slots one per cycle through the shared store read
// port, then waits for the update pipeline to drain.
// Draw: each slot holding an active particle is read from the particle
// store and emitted from its registered read; idle slots are skipped.
// Reset clears every alive bit and loads life_start with 3.0; the particle
// store itself is not cleared, no sweep is needed.
// A result waits in the output register while the receiver stalls; the
// sequencer pauses until it is taken.
module particle_pool_stepper_core
    import pps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in               i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out              o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [LIFE_W-1:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    pps_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_mode    (i_in_data.mode),
        .o_in_ready(o_in_ready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    pps_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cfg_wr   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

endmodule
